// ----- rtl/core/terminal_line_command_parser_core_defines.svh -----
// Assertion macros shared by the parser checker.
`ifndef TERMINAL_LINE_COMMAND_PARSER_CORE_DEFINES_SVH
`define TERMINAL_LINE_COMMAND_PARSER_CORE_DEFINES_SVH
`define TLCP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define TLCP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`endif

// ----- rtl/core/tlcp_pkg.sv -----
// Shared types and constants of the terminal line command parser.
`default_nettype none
package tlcp_pkg;
  localparam int unsigned LineCap = 128;
  localparam int unsigned AddrW = $clog2(LineCap);
  localparam int unsigned CntW = $clog2(LineCap + 1);

  localparam logic [3:0] ActNone = 4'd0;
  localparam logic [3:0] ActEcho = 4'd1;
  localparam logic [3:0] ActBell = 4'd2;
  localparam logic [3:0] ActErase = 4'd3;
  localparam logic [3:0] ActReprint = 4'd4;
  localparam logic [3:0] ActClear = 4'd5;
  localparam logic [3:0] ActDone = 4'd6;
  localparam logic [3:0] ActOvf = 4'd7;
  localparam logic [3:0] ActRxErr = 4'd8;

  localparam logic [3:0] CmdEmpty = 4'd0;
  localparam logic [3:0] CmdErase = 4'd1;
  localparam logic [3:0] CmdHelp = 4'd2;
  localparam logic [3:0] CmdModeQ = 4'd3;
  localparam logic [3:0] CmdModeSet = 4'd4;
  localparam logic [3:0] CmdMsg = 4'd5;
  localparam logic [3:0] CmdNext = 4'd6;
  localparam logic [3:0] CmdPrev = 4'd7;
  localparam logic [3:0] CmdReset = 4'd8;
  localparam logic [3:0] CmdScroll = 4'd9;
  localparam logic [3:0] CmdTest = 4'd10;
  localparam logic [3:0] CmdUnknown = 4'd11;

  localparam logic [1:0] ArgNone = 2'd0;
  localparam logic [1:0] ArgOk = 2'd1;
  localparam logic [1:0] ArgBig = 2'd2;
  localparam logic [1:0] ArgSyntax = 2'd3;

  localparam logic [7:0] ChBs = 8'd8;
  localparam logic [7:0] ChLf = 8'd10;
  localparam logic [7:0] ChFf = 8'd12;
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChNak = 8'd21;
  localparam logic [7:0] ChEsc = 8'd27;
  localparam logic [7:0] ChDel = 8'h7f;

  typedef struct packed {
    logic       scan_start;
    logic       scan_step;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_last;
  } dp_sts_t;

  // Keyword character at position p (0..6), in match order.
  function automatic logic [6:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [55:0] s;
    begin
      unique case (k)
        4'd0: s = {"erase", 16'h0};
        4'd1: s = {"help", 24'h0};
        4'd2: s = {"mode", 24'h0};
        4'd3: s = {"msg ", 24'h0};
        4'd4: s = {"next", 24'h0};
        4'd5: s = {"prev", 24'h0};
        4'd6: s = {"reset", 16'h0};
        4'd7: s = "scroll ";
        4'd8: s = {"test", 24'h0};
        default: s = '0;
      endcase
      kw_char = s[8'd54 - {p, 3'b000} -: 7];
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/tlcp_ram.sv -----
// Generic RAM with one write port and one registered read port.
`default_nettype none
module tlcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/tlcp_datapath.sv -----
// Line store, line-end scanner and command decoder of the parser.
`default_nettype none
module tlcp_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       we_i,
  input  wire logic [6:0]                 wchar_i,
  input  wire logic [tlcp_pkg::CntW-1:0]  fill_i,
  input  wire tlcp_pkg::dp_cmd_t          cmd_i,
  output tlcp_pkg::dp_sts_t               sts_o,
  output logic [3:0]                      command_o,
  output logic [7:0]                      arg_value_o,
  output logic [1:0]                      arg_status_o,
  output logic [2:0]                      text_offset_o
);
  import tlcp_pkg::*;
  // Scan: each step issues the read of address i and evaluates the data of address i-1.
  logic [CntW-1:0] ridx_q, ridx_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            pend_q, pend_d;
  logic [6:0]      rdata;
  logic [8:0]      kwok_q, kwok_d;
  logic [1:0]      ph_q, ph_d; // 0 skip, 1 digits, 2 done
  logic            any_q, any_d, big_q, big_d, syn_q, syn_d;
  logic [7:0]      acc_q, acc_d;
  logic [11:0]     prod;
  logic [3:0]      cmd;
  logic            argcmd;

  tlcp_ram #(.Width(7), .Depth(LineCap)) u_ram (
    .clk_i, .we_i, .waddr_i(fill_i[AddrW-1:0]), .wdata_i(wchar_i),
    .raddr_i(cmd_i.scan_start ? AddrW'(0) : ridx_q[AddrW-1:0]), .rdata_o(rdata));

  assign sts_o.scan_last = pend_q && (ridx_q >= fill_i);
  assign prod = {4'd0, acc_q} * 12'd10 + {8'd0, rdata[3:0]};

  always_comb begin
    ridx_d = ridx_q; pos_d = pos_q; pend_d = pend_q; kwok_d = kwok_q;
    ph_d = ph_q; any_d = any_q; big_d = big_q; syn_d = syn_q; acc_d = acc_q;
    if (cmd_i.scan_start) begin
      ridx_d = CntW'(1); pos_d = '0; pend_d = 1'b1; kwok_d = '1;
      ph_d = 2'd0; any_d = 1'b0; big_d = 1'b0; syn_d = 1'b0; acc_d = '0;
    end else if (cmd_i.scan_step && pend_q) begin
      if (pos_q >= fill_i) begin
        pend_d = 1'b0;
      end else begin
        for (int k = 0; k < 9; k++) begin
          if (pos_q < CntW'(7) && kw_char(4'(k), pos_q[2:0]) != 7'd0 &&
              kw_char(4'(k), pos_q[2:0]) != rdata) kwok_d[k] = 1'b0;
        end
        if (pos_q >= CntW'(4)) begin
          priority if (ph_q == 2'd0) begin
            if (rdata > 7'h20) begin
              ph_d = 2'd1;
              if (rdata < 7'h30 || rdata > 7'h39) begin
                syn_d = 1'b1; ph_d = 2'd2;
              end else begin
                any_d = 1'b1; acc_d = {4'd0, rdata[3:0]};
              end
            end
          end else if (ph_q == 2'd1) begin
            if (rdata <= 7'h20) ph_d = 2'd2;
            else if (rdata < 7'h30 || rdata > 7'h39) begin
              syn_d = 1'b1; ph_d = 2'd2;
            end else if (!big_q) begin
              if (prod > 12'd255) big_d = 1'b1;
              else acc_d = prod[7:0];
            end
          end else begin
          end
        end
        pos_d = pos_q + CntW'(1);
        ridx_d = ridx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end
  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d; pos_q <= pos_d; kwok_q <= kwok_d; ph_q <= ph_d;
    any_q <= any_d; big_q <= big_d; syn_q <= syn_d; acc_q <= acc_d;
  end

  always_comb begin
    cmd = CmdUnknown; text_offset_o = 3'd0; argcmd = 1'b0;
    priority if (kwok_q[0] && fill_i == CntW'(5)) cmd = CmdErase;
    else if (kwok_q[1] && fill_i == CntW'(4)) cmd = CmdHelp;
    else if (kwok_q[2] && fill_i >= CntW'(4)) begin
      if (fill_i > CntW'(4)) begin cmd = CmdModeSet; argcmd = 1'b1; end
      else cmd = CmdModeQ;
    end
    else if (kwok_q[3] && fill_i >= CntW'(4)) begin cmd = CmdMsg; text_offset_o = 3'd4; end
    else if (kwok_q[4] && fill_i == CntW'(4)) cmd = CmdNext;
    else if (kwok_q[5] && fill_i == CntW'(4)) cmd = CmdPrev;
    else if (kwok_q[6] && fill_i == CntW'(5)) cmd = CmdReset;
    else if (kwok_q[7] && fill_i >= CntW'(7)) begin
      cmd = CmdScroll; text_offset_o = 3'd7;
    end
    else if (kwok_q[8] && fill_i >= CntW'(4)) begin cmd = CmdTest; argcmd = 1'b1; end
    else if (fill_i == '0) cmd = CmdEmpty;
    else cmd = CmdUnknown;
    command_o = cmd;
    arg_value_o = 8'd0; arg_status_o = ArgNone;
    if (argcmd) begin
      priority if (syn_q || !any_q) arg_status_o = ArgSyntax;
      else if (big_q) arg_status_o = ArgBig;
      else begin arg_status_o = ArgOk; arg_value_o = acc_q; end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/tlcp_ctrl.sv -----
// Controller: byte classification, fill count and handshake sequencing.
`default_nettype none
module tlcp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                rx_byte_i,
  input  wire logic                      rx_error_i,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_data_i,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [3:0]                     action_o,
  output logic [6:0]                     echo_char_o,
  output logic                           we_o,
  output logic [6:0]                     wchar_o,
  output logic [tlcp_pkg::CntW-1:0]      fill_o,
  output tlcp_pkg::dp_cmd_t              cmd_o,
  input  wire tlcp_pkg::dp_sts_t         sts_i
);
  import tlcp_pkg::*;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            cr_q, cr_d, en_q;
  logic [3:0]      act_q, act_d;
  logic [6:0]      echo_q, echo_d;
  logic            acc;

  assign in_stall = (state_q != StIdle);
  assign cfg_ready = 1'b1;
  assign acc = in_valid && !in_stall;
  assign out_valid = (state_q == StOut);
  assign action_o = act_q;
  assign echo_char_o = echo_q;
  assign fill_o = fill_q;
  assign wchar_o = rx_byte_i[6:0];

  always_comb begin
    state_d = state_q; fill_d = fill_q; cr_d = cr_q; act_d = act_q; echo_d = echo_q;
    we_o = 1'b0; cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          act_d = ActNone; echo_d = 7'd0; state_d = StOut;
          if (!en_q) begin
          end else if (rx_error_i) begin
            fill_d = '0; act_d = ActRxErr;
          end else begin
            priority if (rx_byte_i == ChLf || rx_byte_i == ChCr) begin
              if (fill_q != '0 || ((rx_byte_i == ChCr) == cr_q)) begin
                cr_d = (rx_byte_i == ChCr); act_d = ActDone;
                cmd_o.scan_start = 1'b1; state_d = StScan;
              end
            end else if (rx_byte_i == ChBs || rx_byte_i == ChDel) begin
              if (fill_q != '0) begin fill_d = fill_q - CntW'(1); act_d = ActErase; end
            end else if (rx_byte_i == ChFf) act_d = ActReprint;
            else if (rx_byte_i == ChNak) begin fill_d = '0; act_d = ActClear; end
            else if (rx_byte_i == ChEsc) begin
            end else if (rx_byte_i < 8'h20 || rx_byte_i > 8'h7f) act_d = ActBell;
            else begin
              we_o = 1'b1; echo_d = rx_byte_i[6:0];
              if (fill_q + CntW'(1) >= CntW'(LineCap - 1)) begin
                fill_d = '0; act_d = ActOvf;
              end else begin
                fill_d = fill_q + CntW'(1); act_d = ActEcho;
              end
            end
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = StOut;
      end
      StOut: begin
        if (!out_stall) begin
          state_d = StIdle;
          if (act_q == ActDone) fill_d = '0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; fill_q <= '0; cr_q <= 1'b0; en_q <= 1'b1;
      act_q <= ActNone;
    end else begin
      state_q <= state_d; fill_q <= fill_d; cr_q <= cr_d; act_q <= act_d;
      if (cfg_valid && cfg_ready) en_q <= cfg_data_i;
    end
  end
  always_ff @(posedge clk_i) echo_q <= echo_d;
endmodule
`default_nettype wire

// ----- rtl/core/terminal_line_command_parser_core.sv -----
// Top level of the terminal line command parser.
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     rx_byte_i, rx_error_i
//   out      output     out_valid / out_stall   action_o .. text_offset_o
//   cfg      input      cfg_valid / cfg_ready   cfg_data_i (input_enable)
// An ordinary byte is accepted in the idle state, then its result beat is given in the output state.
// A line end passes through the scan state, which reads the line store, before its result beat.
// The longest line holds 126 stored characters.
// The scan pace is set by the single read port of the line store.
// Reset clears the fill count and sets input_enable; a stalled result holds.
`default_nettype none
module terminal_line_command_parser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       rx_error_i,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data_i,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      action_o,
  output logic [6:0]      echo_char_o,
  output logic [3:0]      command_o,
  output logic [7:0]      arg_value_o,
  output logic [1:0]      arg_status_o,
  output logic [2:0]      text_offset_o
);
  import tlcp_pkg::*;
  logic            we;
  logic [6:0]      wchar;
  logic [CntW-1:0] fill;
  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [3:0]      dcmd;
  logic [7:0]      dval;
  logic [1:0]      dst;
  logic [2:0]      doff;
  logic            done;

  tlcp_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid, .in_stall, .rx_byte_i, .rx_error_i,
    .cfg_valid, .cfg_ready, .cfg_data_i, .out_valid, .out_stall, .action_o,
    .echo_char_o, .we_o(we), .wchar_o(wchar), .fill_o(fill), .cmd_o(cmd), .sts_i(sts));
  tlcp_datapath u_dp (.clk_i, .rst_ni, .we_i(we), .wchar_i(wchar), .fill_i(fill),
    .cmd_i(cmd), .sts_o(sts), .command_o(dcmd), .arg_value_o(dval),
    .arg_status_o(dst), .text_offset_o(doff));

  assign done = (action_o == ActDone);
  assign command_o = done ? dcmd : 4'd0;
  assign arg_value_o = done ? dval : 8'd0;
  assign arg_status_o = done ? dst : 2'd0;
  assign text_offset_o = done ? doff : 3'd0;
endmodule
`default_nettype wire

// ----- rtl/core/tlcp_checker.sv -----
// Port-level checker of the parser, bound to the top level.
`include "terminal_line_command_parser_core_defines.svh"
`default_nettype none
module tlcp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] action_o,
  input wire logic [3:0] command_o,
  input wire logic [1:0] arg_status_o
);
  import tlcp_pkg::*;
  `TLCP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && out_stall |=> out_valid && $stable(action_o))
  `TLCP_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_valid |-> in_stall)
  `TLCP_ASSERT(a_cmd_only_done, clk_i, rst_ni, out_valid && action_o != ActDone |-> command_o == CmdEmpty && arg_status_o == ArgNone)
  `TLCP_ASSERT_NORST(a_reset_idle, clk_i, !rst_ni |-> !out_valid)
endmodule
bind terminal_line_command_parser_core tlcp_checker u_chk (.clk_i, .rst_ni, .in_valid,
  .in_stall, .out_valid, .out_stall, .action_o, .command_o, .arg_status_o);
`default_nettype wire
